@@ rtl/core/pcp_pkg.sv @@
`timescale 1ns / 1ps
package pcp_pkg;

  localparam int COORD_BITS = 20;
  localparam int FRAC_BITS  = 8;
  localparam int ROT_BITS   = 16;
  localparam int ROT_FRAC   = 14;
  localparam int OFS_BITS   = 20;
  localparam int FOCAL_BITS = 16;
  localparam int FOCAL_FRAC = 4;
  localparam int RES_BITS   = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 3 * OFS_BITS;

  // translated point / centred pixel offset
  localparam int CTR_W  = RES_BITS - 1 + FRAC_BITS;
  localparam int PW     = ((COORD_BITS > CTR_W) ? COORD_BITS : CTR_W) + 1;
  localparam int PROD_W = ROT_BITS + PW;
  localparam int ACC_W  = PROD_W + 2;
  localparam int R_W    = ACC_W - ROT_FRAC;
  localparam int MAG_W  = (R_W > PW) ? R_W : PW;
  localparam int MF_W   = (FOCAL_BITS > COORD_BITS) ? FOCAL_BITS : COORD_BITS;
  localparam int T_W    = MAG_W + MF_W;
  localparam int SH_MAX = (FRAC_BITS > FOCAL_FRAC) ? FRAC_BITS : FOCAL_FRAC;
  localparam int N_W    = T_W + SH_MAX;
  localparam int DEN_A  = R_W + FOCAL_FRAC;
  localparam int DEN_B  = FOCAL_BITS + FRAC_BITS;
  localparam int DEN_W  = (DEN_A > DEN_B) ? DEN_A : DEN_B;
  localparam int Q_W    = COORD_BITS;
  localparam int CMP_A  = N_W;
  localparam int CMP_B  = DEN_W + Q_W;
  localparam int CMP_W  = ((CMP_A > CMP_B) ? CMP_A : CMP_B) + 1;

  localparam logic [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  localparam logic [CFG_IDX_W-1:0] CFG_ROT_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT_Z  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FOCAL  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd6;

  typedef struct packed {
    logic [2:0][2:0][ROT_BITS-1:0] rot;
    logic [2:0][OFS_BITS-1:0]      ofs;
    logic [FOCAL_BITS-1:0]         focal;
    logic [RES_BITS-1:0]           width;
    logic [RES_BITS-1:0]           height;
  } cfg_t;

  typedef struct packed {
    logic                         action;
    logic signed [COORD_BITS-1:0] coord_a;
    logic signed [COORD_BITS-1:0] coord_b;
    logic signed [COORD_BITS-1:0] coord_c;
  } sample_t;

  typedef struct packed {
    logic [N_W-1:0]               num_a;
    logic [N_W-1:0]               num_b;
    logic [DEN_W-1:0]             den;
    logic                         neg_a;
    logic                         neg_b;
    logic                         bad;
    logic signed [COORD_BITS-1:0] out_c;
  } div_req_t;

  typedef struct packed {
    logic [Q_W-1:0]               q_a;
    logic [Q_W-1:0]               q_b;
    logic                         ovf_a;
    logic                         ovf_b;
    logic                         neg_a;
    logic                         neg_b;
    logic                         bad;
    logic signed [COORD_BITS-1:0] out_c;
  } div_res_t;

endpackage

@@ rtl/core/pcp_sample_if.sv @@
`timescale 1ns / 1ps
interface pcp_sample_if;
  import pcp_pkg::*;

  logic                         valid;
  logic                         ready;
  logic                         action;
  logic signed [COORD_BITS-1:0] coord_a;
  logic signed [COORD_BITS-1:0] coord_b;
  logic signed [COORD_BITS-1:0] coord_c;

  modport source (output valid, action, coord_a, coord_b, coord_c, input ready);
  modport sink (input valid, action, coord_a, coord_b, coord_c, output ready);
endinterface

@@ rtl/core/pcp_result_if.sv @@
`timescale 1ns / 1ps
interface pcp_result_if;
  import pcp_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] out_a;
  logic signed [COORD_BITS-1:0] out_b;
  logic signed [COORD_BITS-1:0] out_c;
  logic                         bad_depth;
  logic                         saturated;

  modport source (output valid, out_a, out_b, out_c, bad_depth, saturated, input ready);
  modport sink (input valid, out_a, out_b, out_c, bad_depth, saturated, output ready);
endinterface

@@ rtl/core/pcp_cfg.sv @@
`timescale 1ns / 1ps
module pcp_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [pcp_pkg::CFG_IDX_W-1:0]      cfg_wr_index,
  input  logic [pcp_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
  output pcp_pkg::cfg_t                      cfg
);
  import pcp_pkg::*;

  localparam logic [ROT_BITS-1:0] ONE  = ROT_BITS'(1 << ROT_FRAC);
  localparam logic [ROT_BITS-1:0] ZERO = '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      // identity rotation
      cfg.rot    <= {ONE, ZERO, ZERO, ZERO, ONE, ZERO, ZERO, ZERO, ONE};
      cfg.ofs    <= '0;
      cfg.focal  <= FOCAL_BITS'(8000);
      cfg.width  <= RES_BITS'(640);
      cfg.height <= RES_BITS'(480);
    end else if (cfg_wr_en) begin
      unique case (cfg_wr_index)
        CFG_ROT_X:  cfg.rot[0]  <= cfg_wr_data[3*ROT_BITS-1:0];
        CFG_ROT_Y:  cfg.rot[1]  <= cfg_wr_data[3*ROT_BITS-1:0];
        CFG_ROT_Z:  cfg.rot[2]  <= cfg_wr_data[3*ROT_BITS-1:0];
        CFG_OFFSET: cfg.ofs     <= cfg_wr_data[3*OFS_BITS-1:0];
        CFG_FOCAL:  cfg.focal   <= cfg_wr_data[FOCAL_BITS-1:0];
        CFG_WIDTH:  cfg.width   <= cfg_wr_data[RES_BITS-1:0];
        CFG_HEIGHT: cfg.height  <= cfg_wr_data[RES_BITS-1:0];
        default: ;
      endcase
    end
  end
endmodule

@@ rtl/core/pcp_front.sv @@
`timescale 1ns / 1ps
module pcp_front (
  input  logic              clk,
  input  logic              rst,
  input  pcp_pkg::cfg_t     cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  pcp_pkg::sample_t  in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output pcp_pkg::div_req_t out_item
);
  import pcp_pkg::*;

  logic ld1, ld2, ld3, ld4, ld5;
  logic s1_v, s2_v, s3_v, s4_v, s5_v;

  // stage 1: translate, center pixel
  logic                         s1_act;
  logic signed [PW-1:0]         s1_p [3];
  logic signed [PW-1:0]         s1_dx, s1_dy;
  logic signed [COORD_BITS-1:0] s1_d;
  // stage 2: rotation products
  logic                         s2_act;
  logic signed [PROD_W-1:0]     s2_prod [3][3];
  logic signed [PW-1:0]         s2_dx, s2_dy;
  logic signed [COORD_BITS-1:0] s2_d;
  // stage 3: row sums
  logic                         s3_act;
  logic signed [R_W-1:0]        s3_r [3];
  logic signed [PW-1:0]         s3_dx, s3_dy;
  logic signed [COORD_BITS-1:0] s3_d;
  // stage 4: operand select
  logic                         s4_act;
  logic [MAG_W-1:0]             s4_ma, s4_mb;
  logic [MF_W-1:0]              s4_mf;
  logic [DEN_W-1:0]             s4_den;
  logic                         s4_neg_a, s4_neg_b, s4_bad;
  logic signed [COORD_BITS-1:0] s4_c;

  logic signed [COORD_BITS-1:0] c_in [3];
  logic [PW-1:0]                cx_u, cy_u;
  logic [FOCAL_BITS-1:0]        focal_eff;
  logic [T_W-1:0]               ta, tb;

  assign ld5 = !s5_v || out_ready;
  assign ld4 = !s4_v || ld5;
  assign ld3 = !s3_v || ld4;
  assign ld2 = !s2_v || ld3;
  assign ld1 = !s1_v || ld2;
  assign in_ready  = ld1;
  assign out_valid = s5_v;

  assign c_in[0] = in_item.coord_a;
  assign c_in[1] = in_item.coord_b;
  assign c_in[2] = in_item.coord_c;
  assign cx_u = PW'(cfg.width[RES_BITS-1:1]) << FRAC_BITS;
  assign cy_u = PW'(cfg.height[RES_BITS-1:1]) << FRAC_BITS;
  assign focal_eff = (cfg.focal == '0) ? FOCAL_BITS'(1) : cfg.focal;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
      s5_v <= 1'b0;
    end else begin
      if (ld1) s1_v <= in_valid;
      if (ld2) s2_v <= s1_v;
      if (ld3) s3_v <= s2_v;
      if (ld4) s4_v <= s3_v;
      if (ld5) s5_v <= s4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      s1_act <= in_item.action;
      for (int k = 0; k < 3; k++) begin
        s1_p[k] <= PW'(c_in[k]) + PW'($signed(cfg.ofs[k]));
      end
      s1_dx <= PW'(in_item.coord_a) - $signed(cx_u);
      s1_dy <= PW'(in_item.coord_b) - $signed(cy_u);
      s1_d  <= in_item.coord_c;
    end
  end

  always_ff @(posedge clk) begin
    if (ld2) begin
      s2_act <= s1_act;
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          s2_prod[i][k] <= $signed(cfg.rot[i][k]) * s1_p[k];
        end
      end
      s2_dx <= s1_dx;
      s2_dy <= s1_dy;
      s2_d  <= s1_d;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [ACC_W-1:0] acc;
    if (ld3) begin
      s3_act <= s2_act;
      for (int i = 0; i < 3; i++) begin
        acc = ACC_W'(s2_prod[i][0]) + ACC_W'(s2_prod[i][1]) + ACC_W'(s2_prod[i][2]);
        // arithmetic shift drop of the rotation fraction rounds toward minus infinity
        s3_r[i] <= acc[ACC_W-1:ROT_FRAC];
      end
      s3_dx <= s2_dx;
      s3_dy <= s2_dy;
      s3_d  <= s2_d;
    end
  end

  always_ff @(posedge clk) begin
    logic d_neg;
    if (ld4) begin
      d_neg = s3_d[COORD_BITS-1];
      s4_act <= s3_act;
      if (s3_act) begin
        s4_ma    <= s3_dx[PW-1] ? MAG_W'($unsigned(-s3_dx)) : MAG_W'($unsigned(s3_dx));
        s4_mb    <= s3_dy[PW-1] ? MAG_W'($unsigned(-s3_dy)) : MAG_W'($unsigned(s3_dy));
        s4_mf    <= d_neg ? MF_W'($unsigned(-s3_d)) : MF_W'($unsigned(s3_d));
        s4_den   <= DEN_W'(focal_eff) << FRAC_BITS;
        s4_neg_a <= s3_dx[PW-1] ^ d_neg;
        s4_neg_b <= !(s3_dy[PW-1] ^ d_neg);
        s4_bad   <= 1'b0;
        s4_c     <= s3_d;
      end else begin
        s4_ma    <= s3_r[0][R_W-1] ? MAG_W'($unsigned(-s3_r[0])) : MAG_W'($unsigned(s3_r[0]));
        s4_mb    <= s3_r[1][R_W-1] ? MAG_W'($unsigned(-s3_r[1])) : MAG_W'($unsigned(s3_r[1]));
        s4_mf    <= MF_W'(focal_eff);
        s4_den   <= DEN_W'($unsigned(s3_r[2])) << FOCAL_FRAC;
        s4_neg_a <= s3_r[0][R_W-1];
        s4_neg_b <= s3_r[1][R_W-1];
        s4_bad   <= s3_r[2][R_W-1] || (s3_r[2] == '0);
        s4_c     <= '0;
      end
    end
  end

  assign ta = T_W'(s4_ma) * T_W'(s4_mf);
  assign tb = T_W'(s4_mb) * T_W'(s4_mf);

  always_ff @(posedge clk) begin
    if (ld5) begin
      out_item.num_a <= s4_act ? (N_W'(ta) << FOCAL_FRAC) : (N_W'(ta) << FRAC_BITS);
      out_item.num_b <= s4_act ? (N_W'(tb) << FOCAL_FRAC) : (N_W'(tb) << FRAC_BITS);
      out_item.den   <= s4_den;
      out_item.neg_a <= s4_neg_a;
      out_item.neg_b <= s4_neg_b;
      out_item.bad   <= s4_bad;
      out_item.out_c <= s4_c;
    end
  end
endmodule

@@ rtl/core/pcp_div.sv @@
`timescale 1ns / 1ps
module pcp_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  pcp_pkg::div_req_t in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output pcp_pkg::div_res_t out_item
);
  import pcp_pkg::*;

  typedef struct packed {
    logic [N_W-1:0]               rem_a;
    logic [N_W-1:0]               rem_b;
    logic [Q_W-1:0]               q_a;
    logic [Q_W-1:0]               q_b;
    logic                         ovf_a;
    logic                         ovf_b;
    logic [DEN_W-1:0]             den;
    logic                         neg_a;
    logic                         neg_b;
    logic                         bad;
    logic signed [COORD_BITS-1:0] out_c;
  } div_st_t;

  div_st_t    st   [Q_W+1];
  logic       st_v [Q_W+1];
  logic       ld   [Q_W+1];
  logic [CMP_W-1:0] den_top;

  assign den_top = CMP_W'(in_item.den) << Q_W;
  assign in_ready  = ld[0];
  assign out_valid = st_v[Q_W];
  assign ld[Q_W]   = !st_v[Q_W] || out_ready;

  // quotient range check; past it the remainder stays below den << Q_W
  always_ff @(posedge clk) begin
    if (rst) begin
      st_v[0] <= 1'b0;
    end else if (ld[0]) begin
      st_v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      st[0].rem_a <= in_item.num_a;
      st[0].rem_b <= in_item.num_b;
      st[0].q_a   <= '0;
      st[0].q_b   <= '0;
      st[0].ovf_a <= CMP_W'(in_item.num_a) >= den_top;
      st[0].ovf_b <= CMP_W'(in_item.num_b) >= den_top;
      st[0].den   <= in_item.den;
      st[0].neg_a <= in_item.neg_a;
      st[0].neg_b <= in_item.neg_b;
      st[0].bad   <= in_item.bad;
      st[0].out_c <= in_item.out_c;
    end
  end

  for (genvar j = 0; j < Q_W; j++) begin : g_bit
    localparam int B = Q_W - 1 - j;
    logic [CMP_W-1:0] dsh;

    assign ld[j] = !st_v[j] || ld[j+1];
    assign dsh   = CMP_W'(st[j].den) << B;

    always_ff @(posedge clk) begin
      if (rst) begin
        st_v[j+1] <= 1'b0;
      end else if (ld[j+1]) begin
        st_v[j+1] <= st_v[j];
      end
    end

    always_ff @(posedge clk) begin
      div_st_t nxt;
      if (ld[j+1]) begin
        nxt = st[j];
        if (CMP_W'(st[j].rem_a) >= dsh) begin
          nxt.rem_a  = st[j].rem_a - dsh[N_W-1:0];
          nxt.q_a[B] = 1'b1;
        end
        if (CMP_W'(st[j].rem_b) >= dsh) begin
          nxt.rem_b  = st[j].rem_b - dsh[N_W-1:0];
          nxt.q_b[B] = 1'b1;
        end
        st[j+1] <= nxt;
      end
    end
  end

  assign out_item.q_a   = st[Q_W].q_a;
  assign out_item.q_b   = st[Q_W].q_b;
  assign out_item.ovf_a = st[Q_W].ovf_a;
  assign out_item.ovf_b = st[Q_W].ovf_b;
  assign out_item.neg_a = st[Q_W].neg_a;
  assign out_item.neg_b = st[Q_W].neg_b;
  assign out_item.bad   = st[Q_W].bad;
  assign out_item.out_c = st[Q_W].out_c;
endmodule

@@ rtl/core/pinhole_camera_projection.sv @@
`timescale 1ns / 1ps
// Pipeline from sample transaction to result valid: 5 front stages,
// 21 divider stages, 1 output stage, one stage per quotient bit in the divider.
// Throughput: one transaction per cycle; a stall holds every stage in place and
// empty stages keep filling behind it.
// Reset clears all stage valid bits and loads the default configuration.
module pinhole_camera_projection (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [pcp_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
  input  logic [pcp_pkg::CFG_DATA_W-1:0] cfg_wr_data,
  pcp_sample_if.sink                     sample,
  pcp_result_if.source                   result
);
  import pcp_pkg::*;

  cfg_t     cfg;
  sample_t  smp;
  div_req_t req;
  div_res_t res;
  logic     req_valid, req_ready, res_valid, res_ready;
  logic     o_v, ld_o;
  logic signed [COORD_BITS-1:0] a_val, b_val;
  logic     a_sat, b_sat;

  function automatic logic [COORD_BITS:0] clip(input logic [Q_W-1:0] q,
                                               input logic ovf, input logic neg);
    logic [COORD_BITS-1:0] v;
    logic                  s;
    s = 1'b0;
    if (neg) begin
      if (ovf || (COORD_BITS'(q) > COORD_MIN)) begin
        v = COORD_MIN;
        s = 1'b1;
      end else begin
        v = COORD_BITS'(0) - COORD_BITS'(q);
      end
    end else begin
      if (ovf || (COORD_BITS'(q) > COORD_MAX)) begin
        v = COORD_MAX;
        s = 1'b1;
      end else begin
        v = COORD_BITS'(q);
      end
    end
    return {s, v};
  endfunction

  assign smp.action  = sample.action;
  assign smp.coord_a = sample.coord_a;
  assign smp.coord_b = sample.coord_b;
  assign smp.coord_c = sample.coord_c;

  pcp_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_index (cfg_wr_index),
    .cfg_wr_data  (cfg_wr_data),
    .cfg          (cfg)
  );

  pcp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (sample.valid),
    .in_ready  (sample.ready),
    .in_item   (smp),
    .out_valid (req_valid),
    .out_ready (req_ready),
    .out_item  (req)
  );

  pcp_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req_valid),
    .in_ready  (req_ready),
    .in_item   (req),
    .out_valid (res_valid),
    .out_ready (res_ready),
    .out_item  (res)
  );

  assign ld_o      = !o_v || result.ready;
  assign res_ready = ld_o;
  assign result.valid = o_v;

  assign {a_sat, a_val} = clip(res.q_a, res.ovf_a, res.neg_a);
  assign {b_sat, b_val} = clip(res.q_b, res.ovf_b, res.neg_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      o_v <= 1'b0;
    end else if (ld_o) begin
      o_v <= res_valid;
    end
  end

  // drop the quotients when the rotated depth is not in front of the camera
  always_ff @(posedge clk) begin
    if (ld_o) begin
      result.out_a     <= res.bad ? '0 : a_val;
      result.out_b     <= res.bad ? '0 : b_val;
      result.out_c     <= res.out_c;
      result.bad_depth <= res.bad;
      result.saturated <= !res.bad && (a_sat || b_sat);
    end
  end

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.bad_depth) |->
      (result.out_a == '0 && result.out_b == '0 && result.out_c == '0 && !result.saturated))
    else $error("bad depth result carries nonzero data");

  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.saturated) |->
      ($unsigned(result.out_a) == COORD_MAX || $unsigned(result.out_a) == COORD_MIN ||
       $unsigned(result.out_b) == COORD_MAX || $unsigned(result.out_b) == COORD_MIN))
    else $error("saturated flag without a clipped output");

  a_reset_empty: assert property (@(posedge clk) rst |=> !result.valid)
    else $error("result valid right after reset");

  a_div_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> res_valid)
    else $error("divider output dropped while stalled");
endmodule

@@ tb/sv/pinhole_camera_projection_tb.sv @@
`timescale 1ns / 1ps
module pinhole_camera_projection_tb;
  import pcp_pkg::*;

  localparam logic ACT_PROJECT = 1'b0;
  localparam logic ACT_BACK    = 1'b1;
  localparam int   DRAIN_CYCLES = 40;
  localparam logic signed [COORD_BITS-1:0] CMAX = COORD_MAX;
  localparam logic signed [COORD_BITS-1:0] CMIN = COORD_MIN;
  localparam logic signed [COORD_BITS-1:0] ONE  = 20'sd256;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] out_a;
    logic signed [COORD_BITS-1:0] out_b;
    logic signed [COORD_BITS-1:0] out_c;
    logic                         bad_depth;
    logic                         saturated;
  } point_res_t;

  typedef struct packed {
    sample_t    pt;
    logic       typed;
    point_res_t want;
  } point_row_t;

  localparam point_res_t NONE  = '{default: '0};
  localparam point_res_t BAD   = '{0, 0, 0, 1'b1, 1'b0};

  localparam int N_DIRECTED = 15;
  localparam point_row_t DIRECTED [N_DIRECTED] = '{
    '{'{ACT_PROJECT, 0, 0, ONE},        1'b1, NONE},
    '{'{ACT_PROJECT, 0, 0, 0},          1'b1, BAD},
    '{'{ACT_PROJECT, ONE, ONE, -ONE},   1'b1, BAD},
    '{'{ACT_PROJECT, CMAX, CMAX, CMIN}, 1'b1, BAD},
    '{'{ACT_PROJECT, CMAX, CMAX, 1},    1'b1, '{CMAX, CMAX, 0, 1'b0, 1'b1}},
    '{'{ACT_PROJECT, CMIN, CMIN, 1},    1'b1, '{CMIN, CMIN, 0, 1'b0, 1'b1}},
    '{'{ACT_PROJECT, ONE, -ONE, ONE},   1'b0, NONE},
    '{'{ACT_PROJECT, CMAX, CMIN, CMAX}, 1'b0, NONE},
    '{'{ACT_PROJECT, 1, -1, CMAX},      1'b0, NONE},
    '{'{ACT_BACK, 320 * 256, 240 * 256, ONE}, 1'b1, '{0, 0, ONE, 1'b0, 1'b0}},
    '{'{ACT_BACK, 5 * 256, 7 * 256, 0},       1'b1, NONE},
    '{'{ACT_BACK, 0, 0, -ONE},          1'b0, NONE},
    '{'{ACT_BACK, CMAX, CMAX, CMAX},    1'b0, NONE},
    '{'{ACT_BACK, CMIN, CMIN, CMIN},    1'b0, NONE},
    '{'{ACT_BACK, CMAX, CMIN, -1},      1'b0, NONE}
  };

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_wr_index;
  logic [CFG_DATA_W-1:0] cfg_wr_data;

  pcp_sample_if sample ();
  pcp_result_if result ();

  pinhole_camera_projection dut (
    .clk(clk), .rst(rst), .cfg_wr_en(cfg_wr_en), .cfg_wr_index(cfg_wr_index),
    .cfg_wr_data(cfg_wr_data), .sample(sample.sink), .result(result.source)
  );

  // shadow of the register file
  logic [3*ROT_BITS-1:0] rot_row [3];
  logic [3*OFS_BITS-1:0] cam_ofs;
  logic [FOCAL_BITS-1:0] focal;
  logic [RES_BITS-1:0]   img_w;
  logic [RES_BITS-1:0]   img_h;

  point_row_t pending_q [$];
  point_res_t expected_q [$];
  int  errors;
  bit  calm;
  bit  sample_fire;

  function automatic longint scaled_quot(longint t, longint d, int sh, bit neg,
                                         inout bit sat);
    longint q, r, mag;
    q = t / d;
    r = t % d;
    if (q >= (64'sd1 <<< COORD_BITS)) begin
      sat = 1'b1;
      return neg ? longint'(CMIN) : longint'(CMAX);
    end
    mag = (q <<< sh) + ((r <<< sh) / d);
    if (neg) begin
      if (mag > -longint'(CMIN)) begin
        sat = 1'b1;
        mag = -longint'(CMIN);
      end
      return -mag;
    end
    if (mag > longint'(CMAX)) begin
      sat = 1'b1;
      mag = longint'(CMAX);
    end
    return mag;
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic point_res_t predict_point(sample_t s);
    point_res_t res;
    longint c[3], p[3], rv[3], acc, f, den, dx, dy, d;
    bit sat;
    res = '0;
    sat = 1'b0;
    f = (focal == 0) ? 1 : longint'(focal);
    c[0] = longint'(s.coord_a);
    c[1] = longint'(s.coord_b);
    c[2] = longint'(s.coord_c);
    if (s.action == ACT_PROJECT) begin
      for (int k = 0; k < 3; k++)
        p[k] = c[k] + longint'($signed(cam_ofs[OFS_BITS*k +: OFS_BITS]));
      for (int i = 0; i < 3; i++) begin
        acc = 0;
        for (int k = 0; k < 3; k++)
          acc += longint'($signed(rot_row[i][ROT_BITS*k +: ROT_BITS])) * p[k];
        rv[i] = acc >>> ROT_FRAC;
      end
      if (rv[2] <= 0) begin
        res.bad_depth = 1'b1;
        return res;
      end
      den = rv[2] <<< FOCAL_FRAC;
      res.out_a = COORD_BITS'(scaled_quot(mag(rv[0]) * f, den, FRAC_BITS, rv[0] < 0, sat));
      res.out_b = COORD_BITS'(scaled_quot(mag(rv[1]) * f, den, FRAC_BITS, rv[1] < 0, sat));
    end else begin
      dx = c[0] - (longint'(img_w >> 1) <<< FRAC_BITS);
      dy = c[1] - (longint'(img_h >> 1) <<< FRAC_BITS);
      d = c[2];
      den = f <<< FRAC_BITS;
      res.out_a = COORD_BITS'(scaled_quot(mag(dx) * mag(d), den, FOCAL_FRAC,
                                          (dx < 0) != (d < 0), sat));
      res.out_b = COORD_BITS'(scaled_quot(mag(dy) * mag(d), den, FOCAL_FRAC,
                                          (dy < 0) == (d < 0), sat));
      res.out_c = s.coord_c;
    end
    res.saturated = sat;
    return res;
  endfunction

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(4 * 400000);
    $display("Mismatches found");
    $finish;
  end

  // sample side: hold until accepted, idle now and then
  always @(negedge clk) begin
    if (rst) begin
      sample.valid <= 1'b0;
    end else if (!sample.valid || sample_fire) begin
      if (pending_q.size() > 0 && (calm || $urandom_range(99) >= 16)) begin
        sample.valid   <= 1'b1;
        sample.action  <= pending_q[0].pt.action;
        sample.coord_a <= pending_q[0].pt.coord_a;
        sample.coord_b <= pending_q[0].pt.coord_b;
        sample.coord_c <= pending_q[0].pt.coord_c;
      end else begin
        sample.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk)
    result.ready <= calm || $urandom_range(99) >= 16;

  always @(posedge clk) begin
    point_row_t row;
    point_res_t want, got;
    sample_fire = 1'b0;
    if (!rst && sample.valid && sample.ready) begin
      sample_fire = 1'b1;
      row = pending_q.pop_front();
      want = row.typed ? row.want : predict_point(row.pt);
      expected_q = {expected_q, want};
    end
    if (!rst && result.valid && result.ready) begin
      got = '{result.out_a, result.out_b, result.out_c, result.bad_depth,
              result.saturated};
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction %p", $time, got);
      end else begin
        want = expected_q.pop_front();
        if (got.out_a !== want.out_a || got.out_b !== want.out_b ||
            got.out_c !== want.out_c || got.bad_depth !== want.bad_depth ||
            got.saturated !== want.saturated) begin
          errors++;
          $display("%0t: expected %p actual %p", $time, want, got);
        end
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_wr_en    <= 1'b1;
    cfg_wr_index <= idx;
    cfg_wr_data  <= data;
    case (idx)
      CFG_ROT_X:  rot_row[0] = data[3*ROT_BITS-1:0];
      CFG_ROT_Y:  rot_row[1] = data[3*ROT_BITS-1:0];
      CFG_ROT_Z:  rot_row[2] = data[3*ROT_BITS-1:0];
      CFG_OFFSET: cam_ofs = data;
      CFG_FOCAL:  focal = data[FOCAL_BITS-1:0];
      CFG_WIDTH:  img_w = data[RES_BITS-1:0];
      CFG_HEIGHT: img_h = data[RES_BITS-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_q.size() > 0 || expected_q.size() > 0 || sample.valid)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [ROT_BITS-1:0] rand_rot_entry(bit near);
    if (near)
      return ROT_BITS'($signed($urandom_range(2048)) - 1024);
    return ROT_BITS'($urandom);
  endfunction

  // mode: 0 extremes high, 1 extremes low, else random mostly well-formed
  task automatic load_setting(int mode);
    logic [3*ROT_BITS-1:0] row;
    logic [CFG_DATA_W-1:0] ofs;
    bit wild;
    for (int i = 0; i < 3; i++) begin
      wild = $urandom_range(3) == 0;
      for (int k = 0; k < 3; k++)
        row[ROT_BITS*k +: ROT_BITS] = (k == i && !wild) ?
            ROT_BITS'(16384 + $signed(rand_rot_entry(1'b1))) : rand_rot_entry(!wild);
      if (mode == 0) row = '1;
      if (mode == 1) row = '0;
      write_reg(CFG_IDX_W'(CFG_ROT_X + i), CFG_DATA_W'(row));
    end
    for (int k = 0; k < 3; k++)
      ofs[OFS_BITS*k +: OFS_BITS] = ($urandom_range(1)) ?
          OFS_BITS'($urandom) : OFS_BITS'($signed($urandom_range(8192)) - 4096);
    if (mode == 0) ofs = '1;
    if (mode == 1) ofs = '0;
    write_reg(CFG_OFFSET, ofs);
    write_reg(CFG_FOCAL, CFG_DATA_W'(mode == 0 ? 16'hFFFF : mode == 1 ? 16'd0 :
              ($urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(16000, 2000)))));
    write_reg(CFG_WIDTH,
              CFG_DATA_W'(mode == 0 ? 12'hFFF : mode == 1 ? 12'd1 : 12'($urandom)));
    write_reg(CFG_HEIGHT,
              CFG_DATA_W'(mode == 0 ? 12'hFFF : mode == 1 ? 12'd0 : 12'($urandom)));
  endtask

  task automatic queue_random(int count);
    point_row_t row;
    for (int n = 0; n < count; n++) begin
      row = '0;
      row.pt.action = $urandom_range(1);
      if ($urandom_range(3) == 0) begin
        row.pt.coord_a = COORD_BITS'($urandom);
        row.pt.coord_b = COORD_BITS'($urandom);
        row.pt.coord_c = COORD_BITS'($urandom);
      end else begin
        row.pt.coord_a = COORD_BITS'($signed($urandom_range(65536)) - 32768);
        row.pt.coord_b = COORD_BITS'($signed($urandom_range(65536)) - 32768);
        row.pt.coord_c = COORD_BITS'($urandom_range(65536, 64));
      end
      pending_q = {pending_q, row};
    end
  endtask

  initial begin
    errors = 0;
    calm = 1'b0;
    sample_fire = 1'b0;
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_index = '0;
    cfg_wr_data = '0;
    sample.valid = 1'b0;
    sample.action = ACT_PROJECT;
    sample.coord_a = '0;
    sample.coord_b = '0;
    sample.coord_c = '0;
    result.ready = 1'b0;
    rot_row[0] = 48'd16384;
    rot_row[1] = 48'd16384 << 16;
    rot_row[2] = 48'd16384 << 32;
    cam_ofs = '0;
    focal = 16'd8000;
    img_w = 12'd640;
    img_h = 12'd480;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIRECTED; i++)
      pending_q = {pending_q, DIRECTED[i]};
    wait_drained();

    // reset setting first, then extremes, then random settings
    for (int phase = 0; phase < 8; phase++) begin
      if (phase > 0) load_setting(phase - 1);
      calm = (phase == 3);
      queue_random(85);
      wait_drained();
    end

    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
